// ===== hdl/dmkc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmkc_pkg
// Shared types and constants of the direct-mapped key cache.
// ----------------------------------------------------------------------------
package dmkc_pkg;

    localparam int KEY_W     = 64;
    localparam int COUNT_W   = 11;
    localparam int VAL_W     = 32;  // bits of the key that select the slot

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_ERASE  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] word3;
        logic [KEY_W-1:0] word2;
        logic [KEY_W-1:0] word1;
        logic [KEY_W-1:0] word0;
    } t_key;

    typedef struct packed {
        logic valid;
        t_key key;
    } t_entry;

endpackage

// ===== hdl/dmkc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmkc_if
// Valid/ready channels of the key cache: request beats and result beats.
// ----------------------------------------------------------------------------
interface dmkc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;

    modport source (
        output valid, mode, key_word0, key_word1, key_word2, key_word3,
        input  ready
    );
    modport sink (
        input  valid, mode, key_word0, key_word1, key_word2, key_word3,
        output ready
    );
endinterface

interface dmkc_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [10:0] entry_count;

    modport source (
        output valid, hit, entry_count,
        input  ready
    );
    modport sink (
        input  valid, hit, entry_count,
        output ready
    );
endinterface

// ===== hdl/direct_mapped_key_cache_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_key_cache_top
// Direct-mapped presence cache of 256-bit keys: lookup, insert and erase
// against one slot per key, with a running occupancy count.
// ----------------------------------------------------------------------------
//   Channel   | Dir | Payload                               | Beat
//   i_item    | in  | mode, key_word0..key_word3            | one request
//   o_result  | out | hit, entry_count                      | one result
//
// An accepted beat first has its slot index computed: a mask when SLOTS is a
// power of two, otherwise a two-stage reciprocal remainder. The slot is then
// read from the RAM and updated in the update state, where the result is
// loaded and i_item.ready returns together. After reset a clearing pass writes
// every slot invalid, with i_item.ready low. One item is in work at a time; a
// result held by a stalled o_result blocks only the update cycle of the next
// item.
// ----------------------------------------------------------------------------
module direct_mapped_key_cache_top #(
    parameter int SLOTS = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dmkc_in_if.sink    i_item,
    dmkc_out_if.source o_result
);
    import dmkc_pkg::*;

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int ENTRY_W = $bits(t_entry);

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_clr_addr, n_clr_addr;
    logic                 r_out_valid, n_out_valid;
    logic                 r_hit, n_hit;
    logic [COUNT_W-1:0]   r_count, n_count;
    t_mode                r_mode, n_mode;
    t_key                 r_key, n_key;

    logic                 div_start;
    logic                 div_done;
    logic [IDX_W-1:0]     div_slot;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    t_entry               ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    t_entry               cur;
    logic                 key_hit;

    dmkc_slot_div #(
        .SLOTS (SLOTS)
    ) u_slot_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_value (i_item.key_word0[VAL_W-1:0]),
        .o_done  (div_done),
        .o_slot  (div_slot)
    );

    // slot index stays put from the divider, so the read address is stable
    dmkc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (div_slot),
        .o_rd_data (ram_rdata)
    );

    assign cur     = t_entry'(ram_rdata);
    assign key_hit = cur.valid && (cur.key == r_key);

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid;
        n_hit       = r_hit;
        n_count     = r_count;
        n_mode      = r_mode;
        n_key       = r_key;
        div_start   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = div_slot;
        ram_wdata   = '0;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + IDX_W'(1);
                if (r_clr_addr == IDX_W'(SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_item.valid) begin
                    n_mode    = t_mode'(i_item.mode);
                    n_key     = {i_item.key_word3, i_item.key_word2,
                                 i_item.key_word1, i_item.key_word0};
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold the update until the result register is free
                if (!r_out_valid || o_result.ready) begin
                    if (r_mode == MODE_INSERT) begin
                        ram_we          = 1'b1;
                        ram_wdata.valid = 1'b1;
                        ram_wdata.key   = r_key;
                        if (!cur.valid) begin
                            n_count = r_count + COUNT_W'(1);
                        end
                    end else if (r_mode == MODE_ERASE && key_hit) begin
                        ram_we          = 1'b1;
                        ram_wdata.valid = 1'b0;
                        ram_wdata.key   = r_key;
                        n_count         = r_count - COUNT_W'(1);
                    end
                    n_hit       = key_hit;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit  <= n_hit;
        r_mode <= n_mode;
        r_key  <= n_key;
    end

    assign i_item.ready         = (r_state == ST_IDLE);
    assign o_result.valid       = r_out_valid;
    assign o_result.hit         = r_hit;
    assign o_result.entry_count = r_count;

    a_result_from_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_EXEC)
        else $error("result beat loaded outside the update cycle");

    a_div_done_in_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == ST_DIV)
        else $error("slot index finished while no item waits for it");

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SLOTS > 2047) || (r_count <= COUNT_W'(SLOTS)))
        else $error("occupancy count exceeds the number of slots");

endmodule

// ===== hdl/dmkc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmkc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dmkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/dmkc_slot_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmkc_slot_div
// Slot index unit: low key bits modulo SLOTS. A mask for a power of two,
// otherwise a reciprocal multiply, then one correcting subtract, each registered.
// ----------------------------------------------------------------------------
module dmkc_slot_div #(
    parameter int SLOTS = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [dmkc_pkg::VAL_W-1:0]            i_value,
    output logic                                  o_done,
    output logic [$clog2(SLOTS)-1:0]              o_slot
);
    import dmkc_pkg::*;

    localparam int IDX_W   = $clog2(SLOTS);
    localparam bit IS_POW2 = (SLOTS & (SLOTS - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            logic             r_done;
            logic [IDX_W-1:0] r_slot;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_slot <= i_value[IDX_W-1:0];
                end
            end

            assign o_done = r_done;
            assign o_slot = r_slot;
        end else begin : g_recip
            localparam int               PW       = IDX_W + 1;
            localparam logic [PW-1:0]    SLOTS_PW = PW'(SLOTS);
            // floor(2^32 / SLOTS): the quotient estimate is low by at most one
            localparam logic [VAL_W-1:0] RECIP    =
                VAL_W'((64'd1 << VAL_W) / 64'(SLOTS));

            logic               r_stage;
            logic               r_done;
            logic [PW-1:0]      r_val;
            logic [PW-1:0]      r_quot;
            logic [IDX_W-1:0]   r_slot;
            logic [2*VAL_W-1:0] product;
            logic [PW-1:0]      rem_est;
            logic [PW-1:0]      n_rem;

            // the remainder estimate lies below 2 * SLOTS, so PW low bits hold it
            always_comb begin
                product = (2*VAL_W)'(i_value) * (2*VAL_W)'(RECIP);
                rem_est = r_val - PW'(r_quot * SLOTS_PW);
                n_rem   = (rem_est >= SLOTS_PW) ? (rem_est - SLOTS_PW) : rem_est;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_stage <= 1'b0;
                    r_done  <= 1'b0;
                end else begin
                    r_stage <= i_start;
                    r_done  <= r_stage;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_val  <= i_value[PW-1:0];
                    r_quot <= product[VAL_W +: PW];
                end
                if (r_stage) begin
                    r_slot <= n_rem[IDX_W-1:0];
                end
            end

            assign o_done = r_done;
            assign o_slot = r_slot;
        end
    endgenerate

endmodule
